// ===== src/smart_card_atr_parser_unit_macros.svh =====
// ----------------------------------------------------------------------------
// smart_card_atr_parser_unit_macros.svh
// assertion macros of the atr parser checker
// ----------------------------------------------------------------------------
`ifndef SMART_CARD_ATR_PARSER_UNIT_MACROS_SVH
`define SMART_CARD_ATR_PARSER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define ATRP_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define ATRP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/atrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrp_pkg
// types, codes and defaults of the answer-to-reset parser
// ----------------------------------------------------------------------------
package atrp_pkg;

   // initial byte values
   localparam logic [7:0] TS_DIRECT  = 8'h3B;
   localparam logic [7:0] TS_INVERSE = 8'h3F;

   // defaults when an interface byte is absent
   localparam logic [8:0] FI_DEFAULT = 9'd372;
   localparam logic [3:0] DI_DEFAULT = 4'd1;
   localparam logic [5:0] II_DEFAULT = 6'd50;
   localparam logic [3:0] PI_DEFAULT = 4'd5;
   localparam logic [7:0] WI_DEFAULT = 8'd10;

   // indicator bits of one interface level
   localparam logic [3:0] IND_A = 4'b0001;
   localparam logic [3:0] IND_B = 4'b0010;
   localparam logic [3:0] IND_C = 4'b0100;
   localparam logic [3:0] IND_D = 4'b1000;

   // result outcome codes
   localparam logic [1:0] OUT_HIST   = 2'd0;
   localparam logic [1:0] OUT_DONE   = 2'd1;
   localparam logic [1:0] OUT_BAD_TS = 2'd2;
   localparam logic [1:0] OUT_TRUNC  = 2'd3;

   // parse phase
   typedef enum logic [5:0] {
      PH_TS   = 6'b000001,
      PH_T0   = 6'b000010,
      PH_LV1  = 6'b000100,
      PH_LV2  = 6'b001000,
      PH_HIST = 6'b010000,
      PH_SKIP = 6'b100000
   } atrp_phase_type;

   // input beat
   typedef struct packed {
      logic [7:0] atr_byte;
      logic       last_byte;
   } atrp_req_type;

   // result beat
   typedef struct packed {
      logic [1:0] outcome;
      logic       hist_valid;
      logic [7:0] hist_byte;
      logic       direct_conv;
      logic [8:0] fi_code;
      logic [3:0] di_code;
      logic [5:0] ii_code;
      logic [3:0] pi_code;
      logic [7:0] extra_guard;
      logic [3:0] protocol_t;
      logic [7:0] waiting_int;
      logic [4:0] atr_length;
   } atrp_rsp_type;

   // lowest pending indicator, d when nothing lower is set
   function automatic logic [3:0] lowest_ind(input logic [3:0] mask);
      logic [3:0] sel;
      if (mask[0]) begin
         sel = IND_A;
      end else if (mask[1]) begin
         sel = IND_B;
      end else if (mask[2]) begin
         sel = IND_C;
      end else begin
         sel = IND_D;
      end
      return sel;
   endfunction

endpackage

// ===== src/smart_card_atr_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smart_card_atr_parser_unit
// answer-to-reset byte parser with a registered result beat
// ----------------------------------------------------------------------------
// Takes ATR bytes and returns at most one result beat per byte, in the cycle
// after the byte is accepted: historical bytes pass out one per beat, a bad
// TS or early last byte gives an error beat, and the byte that completes the
// parse gives the final beat with all interface parameters and the consumed
// length. Throughput is one byte per cycle while req_stall is low; the parse
// state and the result register are updated together on each accepted beat.
// req_stall is high only while rsp_stall holds a result beat in the register.
module smart_card_atr_parser_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  atrp_pkg::atrp_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output atrp_pkg::atrp_rsp_type rsp_data
);
   import atrp_pkg::*;

   // parse state
   atrp_phase_type phase_ff, phase_in;
   logic [3:0] pend_ff, pend_in;
   logic [3:0] hist_left_ff, hist_left_in;
   logic [4:0] count_ff, count_in;
   logic       conv_ff, conv_in;
   logic [8:0] fi_ff, fi_in;
   logic [3:0] di_ff, di_in;
   logic [5:0] ii_ff, ii_in;
   logic [3:0] pi_ff, pi_in;
   logic [7:0] guard_ff, guard_in;
   logic [3:0] proto_ff, proto_in;
   logic [7:0] wi_ff, wi_in;

   // result register
   logic         rsp_valid_ff, rsp_valid_in;
   atrp_rsp_type rsp_data_ff, rsp_data_in;

   logic       fire;
   logic [7:0] b;
   logic       last;
   logic [3:0] ind;
   logic       hv;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign fire      = req_valid & ~req_stall;
   assign b         = req_data.atr_byte;
   assign last      = req_data.last_byte;
   assign ind       = lowest_ind(pend_ff);

   // next parse state and result for the beat at the input
   always_comb begin
      phase_in     = phase_ff;
      pend_in      = pend_ff;
      hist_left_in = hist_left_ff;
      count_in     = count_ff + 5'd1;
      conv_in      = conv_ff;
      fi_in        = fi_ff;
      di_in        = di_ff;
      ii_in        = ii_ff;
      pi_in        = pi_ff;
      guard_in     = guard_ff;
      proto_in     = proto_ff;
      wi_in        = wi_ff;
      hv           = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;

      case (phase_ff)
         PH_SKIP: begin
            // trailing bytes, dropped until the buffer ends
            count_in = count_ff;
            if (last) begin
               phase_in = PH_TS;
            end
         end
         PH_TS: begin
            count_in     = 5'd1;
            pend_in      = 4'd0;
            hist_left_in = 4'd0;
            if (b == TS_DIRECT || b == TS_INVERSE) begin
               conv_in  = (b == TS_DIRECT);
               fi_in    = FI_DEFAULT;
               di_in    = DI_DEFAULT;
               ii_in    = II_DEFAULT;
               pi_in    = PI_DEFAULT;
               guard_in = 8'd0;
               proto_in = 4'd0;
               wi_in    = WI_DEFAULT;
               if (last) begin
                  rsp_valid_in        = 1'b1;
                  rsp_data_in.outcome = OUT_TRUNC;
                  phase_in            = PH_TS;
               end else begin
                  phase_in = PH_T0;
               end
            end else begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.outcome = OUT_BAD_TS;
               phase_in            = last ? PH_TS : PH_SKIP;
            end
         end
         default: begin
            // format, interface and historical bytes
            case (phase_ff)
               PH_T0: begin
                  hist_left_in = b[3:0];
                  pend_in      = b[7:4];
                  phase_in     = PH_LV1;
               end
               PH_LV1: begin
                  pend_in = pend_ff & ~ind;
                  if (ind[0]) begin
                     fi_in = {5'd0, b[7:4]};
                     di_in = b[3:0];
                  end else if (ind[1]) begin
                     ii_in = {2'd0, b[7:4]};
                     pi_in = b[3:0];
                  end else if (ind[2]) begin
                     guard_in = b;
                  end else begin
                     proto_in = b[3:0];
                     pend_in  = b[7:4];
                     phase_in = PH_LV2;
                  end
               end
               PH_LV2: begin
                  pend_in = pend_ff & ~ind;
                  if (ind == IND_C) begin
                     wi_in = b;
                  end
               end
               default: begin
                  hist_left_in = hist_left_ff - 4'd1;
                  hv           = 1'b1;
               end
            endcase

            // fall through levels that have no bytes left
            if (phase_in == PH_LV1 && pend_in == 4'd0) begin
               phase_in = PH_LV2;
            end
            if (phase_in == PH_LV2 && pend_in == 4'd0) begin
               phase_in = PH_HIST;
            end

            if (phase_in == PH_HIST && hist_left_in == 4'd0) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.outcome     = OUT_DONE;
               rsp_data_in.hist_valid  = hv;
               rsp_data_in.hist_byte   = hv ? b : 8'd0;
               rsp_data_in.direct_conv = conv_in;
               rsp_data_in.fi_code     = fi_in;
               rsp_data_in.di_code     = di_in;
               rsp_data_in.ii_code     = ii_in;
               rsp_data_in.pi_code     = pi_in;
               rsp_data_in.extra_guard = guard_in;
               rsp_data_in.protocol_t  = proto_in;
               rsp_data_in.waiting_int = wi_in;
               rsp_data_in.atr_length  = count_in;
               phase_in                = last ? PH_TS : PH_SKIP;
            end else if (last) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.outcome = OUT_TRUNC;
               phase_in            = PH_TS;
            end else if (hv) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.outcome    = OUT_HIST;
               rsp_data_in.hist_valid = 1'b1;
               rsp_data_in.hist_byte  = b;
            end
         end
      endcase
   end

   // parse state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TS;
         pend_ff      <= 4'd0;
         hist_left_ff <= 4'd0;
         count_ff     <= 5'd0;
         conv_ff      <= 1'b0;
         fi_ff        <= 9'd0;
         di_ff        <= 4'd0;
         ii_ff        <= 6'd0;
         pi_ff        <= 4'd0;
         guard_ff     <= 8'd0;
         proto_ff     <= 4'd0;
         wi_ff        <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            phase_ff     <= phase_in;
            pend_ff      <= pend_in;
            hist_left_ff <= hist_left_in;
            count_ff     <= count_in;
            conv_ff      <= conv_in;
            fi_ff        <= fi_in;
            di_ff        <= di_in;
            ii_ff        <= ii_in;
            pi_ff        <= pi_in;
            guard_ff     <= guard_in;
            proto_ff     <= proto_in;
            wi_ff        <= wi_in;
            rsp_valid_ff <= rsp_valid_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/atrp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrp_checker
// port-level checks of the atr parser, bound to the top level
// ----------------------------------------------------------------------------
`include "smart_card_atr_parser_unit_macros.svh"

module atrp_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input atrp_pkg::atrp_rsp_type rsp_data
);
   import atrp_pkg::*;

   // a held result beat stays put
   `ATRP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "result beat changed while stalled")

   // input backpressure only from a blocked result register
   `ATRP_ASSERT_IMPL(a_req_stall_cause, req_stall, rsp_valid && rsp_stall, "input stalled with result path free")

   // no result beat without an accepted input beat
   `ATRP_ASSERT_NEXT(a_no_spurious, !(req_valid && !req_stall) && !(rsp_valid && rsp_stall), !rsp_valid, "result beat without input beat")

   // result register empty right after reset
   `ATRP_ASSERT_IMPL(a_reset_empty, $past(reset), !rsp_valid, "result valid after reset")

endmodule

bind smart_card_atr_parser_unit atrp_checker u_atrp_checker (.*);
